### src/dtp_pkg.sv
// Shared types, codes and constants of the duration token parser.
package dtp_pkg;

  // Line length and position counter limits
  localparam int LINE_MAX = 256;
  localparam int POS_W    = 8;
  localparam logic [POS_W-1:0] POS_CAP =
    (LINE_MAX > 256) ? 8'd255 : POS_W'(LINE_MAX - 1);

  // Value widths and limits
  localparam int VAL_W = 20;
  localparam logic [VAL_W-1:0] SAT20         = 20'hFFFFF;
  localparam logic [VAL_W-1:0] MAX_DELAY_RST = 20'd604800;

  // Unit multipliers in seconds
  localparam int MUL_W = 17;
  localparam logic [MUL_W-1:0] MUL_SEC  = 17'd1;
  localparam logic [MUL_W-1:0] MUL_MIN  = 17'd60;
  localparam logic [MUL_W-1:0] MUL_HOUR = 17'd3600;
  localparam logic [MUL_W-1:0] MUL_DAY  = 17'd86400;

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_D     = 8'h64;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_TIME = 2'd1;
  localparam logic [1:0] ST_NO_MSG  = 2'd2;
  localparam logic [1:0] ST_TOO_FAR = 2'd3;

  // One input character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } dtp_in_t;

  // One result
  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] delay_seconds;
    logic [POS_W-1:0] message_start;
  } dtp_out_t;

  // Parse state after the last character, handed to the result path
  typedef struct packed {
    logic             in_num;
    logic [VAL_W-1:0] number;
    logic [VAL_W-1:0] total;
    logic             found_digit;
    logic             message_seen;
    logic [POS_W-1:0] start_offset;
  } dtp_snap_t;

endpackage

### src/duration_token_parser.sv
// Top level of the duration token parser.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid, in_stall | dtp_in_t  (ch, last)
//   out_    | output    | out_valid, out_stall | dtp_out_t (status, delay_seconds,
//           |           |                    |            message_start)
//   cfg_    | input     | cfg_valid, cfg_ready | 20-bit max_delay
//
// One character is taken every cycle while in_stall is low; the scanner state updates at the transfer.
// A character marked last passes its result through the snapshot register and
// then the output register.
// in_stall rises only when both result stages hold a result and out_stall is high.
// Synchronous active-low reset clears the parse state and sets max_delay to 604800.
// cfg_ready is always high; write max_delay only while no result is pending.
module duration_token_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dtp_pkg::dtp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dtp_pkg::dtp_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtp_pkg::VAL_W-1:0]     cfg_data
);

  logic                        in_acc;
  logic                        busy;
  dtp_pkg::dtp_snap_t          snap;
  logic [dtp_pkg::VAL_W-1:0]   max_delay_r;

  assign in_stall  = busy;
  assign in_acc    = in_valid && !busy;
  assign cfg_ready = 1'b1;

  // Hold the delay limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_delay_r <= dtp_pkg::MAX_DELAY_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_delay_r <= cfg_data;
    end
  end

  dtp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .in_item (in_data),
    .snap    (snap)
  );

  dtp_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_load (in_acc && in_data.last),
    .snap      (snap),
    .max_delay (max_delay_r),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (busy)
  );

endmodule

### src/dtp_parse.sv
// Character scanner: holds the parse state and updates it once per transfer.
module dtp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  dtp_pkg::dtp_in_t    in_item,
  output dtp_pkg::dtp_snap_t  snap
);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_NUM    = 3'd1;
  localparam logic [2:0] PH_UNIT   = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_MSG    = 3'd4;
  localparam logic [2:0] PH_NOTIME = 3'd5;

  localparam int VW = dtp_pkg::VAL_W;
  localparam int PW = dtp_pkg::POS_W;
  localparam int MW = dtp_pkg::MUL_W;

  logic [2:0]    phase_r,  phase_nxt;
  logic [VW-1:0] number_r, number_nxt;
  logic [VW-1:0] total_r,  total_nxt;
  logic          found_r,  found_nxt;
  logic          msg_r,    msg_nxt;
  logic [PW-1:0] pos_r,    pos_nxt;
  logic [PW-1:0] start_r,  start_nxt;

  logic               is_digit;
  logic               is_space;
  logic               is_unit;
  logic [3:0]         dval;
  logic [MW-1:0]      unit_mul;
  logic [MW-1:0]      mul;
  logic [VW+MW-1:0]   prod;
  logic [VW+MW:0]     tot_sum;
  logic [VW-1:0]      tot_sat;
  logic [VW+3:0]      num10;
  logic [VW-1:0]      num_sat;

  // Decode the character
  always_comb begin
    is_digit = (in_item.ch >= dtp_pkg::CH_0) && (in_item.ch <= dtp_pkg::CH_9);
    is_space = (in_item.ch == dtp_pkg::CH_SPACE);
    dval     = in_item.ch[3:0];
    is_unit  = 1'b1;
    case (in_item.ch)
      dtp_pkg::CH_S: unit_mul = dtp_pkg::MUL_SEC;
      dtp_pkg::CH_M: unit_mul = dtp_pkg::MUL_MIN;
      dtp_pkg::CH_H: unit_mul = dtp_pkg::MUL_HOUR;
      dtp_pkg::CH_D: unit_mul = dtp_pkg::MUL_DAY;
      default: begin
        unit_mul = dtp_pkg::MUL_MIN;
        is_unit  = 1'b0;
      end
    endcase
    // A number ended by anything other than a unit counts as minutes
    mul = unit_mul;
  end

  // Saturating accumulate of the total and of the decimal number
  always_comb begin
    prod    = {{MW{1'b0}}, number_r} * {{VW{1'b0}}, mul};
    tot_sum = {{(MW+1){1'b0}}, total_r} + {1'b0, prod};
    tot_sat = (tot_sum > {{(MW+1){1'b0}}, dtp_pkg::SAT20}) ? dtp_pkg::SAT20
                                                          : tot_sum[VW-1:0];
    num10   = {4'b0, number_r} * (VW+4)'(10) + {{VW{1'b0}}, dval};
    num_sat = (num10 > {4'b0, dtp_pkg::SAT20}) ? dtp_pkg::SAT20 : num10[VW-1:0];
  end

  // Advance the phase
  always_comb begin
    phase_nxt  = phase_r;
    number_nxt = number_r;
    total_nxt  = total_r;
    found_nxt  = found_r;
    msg_nxt    = msg_r;
    start_nxt  = start_r;
    unique case (phase_r)
      PH_LEAD: begin
        if (is_digit) begin
          number_nxt = {{(VW-4){1'b0}}, dval};
          found_nxt  = 1'b1;
          phase_nxt  = PH_NUM;
        end else if (!is_space) begin
          phase_nxt = PH_NOTIME;
        end
      end
      PH_NUM: begin
        if (is_digit) begin
          number_nxt = num_sat;
        end else begin
          total_nxt = tot_sat;
          if (is_unit) begin
            phase_nxt = PH_UNIT;
          end else if (is_space) begin
            phase_nxt = PH_TRAIL;
          end else begin
            msg_nxt   = 1'b1;
            start_nxt = pos_r;
            phase_nxt = PH_MSG;
          end
        end
      end
      PH_UNIT: begin
        if (is_digit) begin
          number_nxt = {{(VW-4){1'b0}}, dval};
          phase_nxt  = PH_NUM;
        end else if (is_space) begin
          phase_nxt = PH_TRAIL;
        end else begin
          msg_nxt   = 1'b1;
          start_nxt = pos_r;
          phase_nxt = PH_MSG;
        end
      end
      PH_TRAIL: begin
        if (!is_space) begin
          msg_nxt   = 1'b1;
          start_nxt = pos_r;
          phase_nxt = PH_MSG;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
    pos_nxt = (pos_r < dtp_pkg::POS_CAP) ? pos_r + PW'(1) : pos_r;
  end

  // Hand the updated state to the result path
  always_comb begin
    snap.in_num       = (phase_nxt == PH_NUM);
    snap.number       = number_nxt;
    snap.total        = total_nxt;
    snap.found_digit  = found_nxt;
    snap.message_seen = msg_nxt;
    snap.start_offset = start_nxt;
  end

  // Hold state between transfers; clear after the last character
  always_ff @(posedge clk) begin
    if (!rst_n || (acc && in_item.last)) begin
      phase_r  <= PH_LEAD;
      number_r <= '0;
      total_r  <= '0;
      found_r  <= 1'b0;
      msg_r    <= 1'b0;
      pos_r    <= '0;
      start_r  <= '0;
    end else if (acc) begin
      phase_r  <= phase_nxt;
      number_r <= number_nxt;
      total_r  <= total_nxt;
      found_r  <= found_nxt;
      msg_r    <= msg_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

### src/dtp_result.sv
// Result path: snapshot register, final total and status, output register.
module dtp_result (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                snap_load,
  input  dtp_pkg::dtp_snap_t                  snap,
  input  logic [dtp_pkg::VAL_W-1:0]           max_delay,
  input  logic                                out_stall,
  output logic                                out_valid,
  output dtp_pkg::dtp_out_t                   out_data,
  output logic                                busy
);

  localparam int VW = dtp_pkg::VAL_W;

  logic               s_valid_r, s_valid_nxt;
  dtp_pkg::dtp_snap_t s_r;
  logic               o_valid_r, o_valid_nxt;
  dtp_pkg::dtp_out_t  o_r, o_nxt;
  logic               o_load;

  logic [VW+5:0]      fin_prod;
  logic [VW+6:0]      fin_sum;
  logic [VW-1:0]      fin;
  logic [VW-1:0]      secs;

  // Move the snapshot on when the output register is free or draining
  assign o_load = s_valid_r && (!o_valid_r || !out_stall);
  assign busy   = s_valid_r && !o_load;

  // Close a trailing bare number as minutes, then judge the total
  always_comb begin
    fin_prod = {6'b0, s_r.number} * (VW+6)'(60);
    fin_sum  = {7'b0, s_r.total} + {1'b0, fin_prod};
    if (s_r.in_num) begin
      fin = (fin_sum > {7'b0, dtp_pkg::SAT20}) ? dtp_pkg::SAT20 : fin_sum[VW-1:0];
    end else begin
      fin = s_r.total;
    end
    secs = (fin == '0) ? VW'(1) : fin;

    o_nxt.status        = dtp_pkg::ST_OK;
    o_nxt.delay_seconds = '0;
    o_nxt.message_start = '0;
    if (!s_r.found_digit) begin
      o_nxt.status = dtp_pkg::ST_NO_TIME;
    end else if (!s_r.message_seen) begin
      o_nxt.status = dtp_pkg::ST_NO_MSG;
    end else if ((secs == dtp_pkg::SAT20) || (secs > max_delay)) begin
      o_nxt.status = dtp_pkg::ST_TOO_FAR;
    end else begin
      o_nxt.delay_seconds = secs;
      o_nxt.message_start = s_r.start_offset;
    end
  end

  // Valid flags of both stages
  always_comb begin
    s_valid_nxt = s_valid_r;
    if (o_load) begin
      s_valid_nxt = 1'b0;
    end
    if (snap_load) begin
      s_valid_nxt = 1'b1;
    end
    o_valid_nxt = o_valid_r;
    if (o_valid_r && !out_stall) begin
      o_valid_nxt = 1'b0;
    end
    if (o_load) begin
      o_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (snap_load) begin
      s_r <= snap;
    end
    if (o_load) begin
      o_r <= o_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_r;

endmodule

### src/dtp_checker.sv
// Port-level checks of the duration token parser, bound to the top level.
module dtp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  dtp_pkg::dtp_in_t              in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  dtp_pkg::dtp_out_t             out_data
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A last character that is taken yields a valid result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |-> ##2 out_valid)
    else $error("result missing after last character");

  // Failed parses carry no delay and no offset
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != dtp_pkg::ST_OK) |->
      (out_data.delay_seconds == '0) && (out_data.message_start == '0))
    else $error("failed status with payload");

  // Accepted delays are at least one second and below the saturation value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == dtp_pkg::ST_OK) |->
      (out_data.delay_seconds != '0) && (out_data.delay_seconds != dtp_pkg::SAT20))
    else $error("ok status with zero or saturated delay");

endmodule

bind duration_token_parser dtp_checker u_dtp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
